/* hdl/sbpt_pkg.sv */
// Shared types and constants for the software breakpoint patch table.
// Holds command codes, status codes, instruction encodings and the
// control/status bundles between the controller and the datapath.
package sbpt_pkg;

	localparam int ADDR_W = 64;
	localparam int WORD_W = 32;
	localparam int ACT_W  = 3;
	localparam int STAT_W = 3;

	// Command codes carried by the action field.
	localparam logic [ACT_W-1:0] ACT_SET       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DISABLE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ENABLE    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = 3'd5;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_INVALID   = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

	// Breakpoint encodings and instruction length fields.
	localparam logic [WORD_W-1:0] EBREAK32   = 32'h0010_0073;
	localparam logic [WORD_W-1:0] EBREAK16   = 32'h0000_9002;
	localparam logic [1:0]        LEN16_MASK = 2'b11;
	localparam logic [4:0]        LEN32_MASK = 5'b11111;
	localparam logic [15:0]       HALF_MASK  = 16'hffff;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // register the accepted request
		logic exec;      // perform a single-result command and load the output
		logic sweep_sel; // table read port follows the sweep index
		logic emit;      // load a restore store for the swept entry
		logic advance;   // step the sweep index
		logic finish;    // sweep done: empty the table and rewind the index
	} sbpt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;     // output register can take a result this cycle
		logic is_clear_all; // held request is a clear-all
		logic any_active;   // at least one active entry exists
		logic cur_hit;      // swept entry is valid and active
		logic at_end;       // sweep index sits on the last entry
	} sbpt_stat_t;

endpackage

/* hdl/sbpt_ctrl.sv */
// Controller state machine for the breakpoint patch table.
// Depends on sbpt_pkg for the command and status bundles.
module sbpt_ctrl import sbpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sbpt_stat_t stat,
	output sbpt_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SWEEP
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   sweep_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (stat.is_clear_all && stat.any_active) begin
						state_q <= S_SWEEP;
					end else if (stat.out_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_SWEEP: begin
					if (sweep_step && stat.at_end) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	// A swept entry with nothing to restore moves on at once; one that needs
	// a store waits for room in the output register.
	assign sweep_step = (state_q == S_SWEEP) && (!stat.cur_hit || stat.out_free);

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid && in_ready_q;
		cmd.exec      = (state_q == S_EXEC) && stat.out_free &&
		                !(stat.is_clear_all && stat.any_active);
		cmd.sweep_sel = (state_q == S_SWEEP);
		cmd.emit      = sweep_step && stat.cur_hit;
		cmd.advance   = sweep_step && !stat.at_end;
		cmd.finish    = sweep_step && stat.at_end;
	end

	assign in_ready = in_ready_q;

endmodule

/* hdl/sbpt_datapath.sv */
// Datapath of the breakpoint patch table: request registers, entry storage,
// address match, result formation and the output register. Uses sbpt_pkg.
module sbpt_datapath import sbpt_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sbpt_cmd_t         cmd,
	output sbpt_stat_t        stat,
	input  logic [ACT_W-1:0]  action,
	input  logic [ADDR_W-1:0] address,
	input  logic [WORD_W-1:0] fetched_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic              store_valid,
	output logic [ADDR_W-1:0] store_address,
	output logic [WORD_W-1:0] store_data,
	output logic              store_half,
	output logic              is_breakpoint,
	output logic              last
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	// Held request.
	logic [ACT_W-1:0]  action_q;
	logic [ADDR_W-1:0] address_q;
	logic [WORD_W-1:0] word_q;

	// Entry storage.
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] active_q;
	logic [ADDR_W-1:0]      entry_addr_q  [TABLE_DEPTH];
	logic                   entry_half_q  [TABLE_DEPTH];
	logic [WORD_W-1:0]      entry_saved_q [TABLE_DEPTH];
	logic [IDX_W-1:0]       sweep_idx_q;

	// Output register.
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic              store_valid_q;
	logic [ADDR_W-1:0] store_address_q;
	logic [WORD_W-1:0] store_data_q;
	logic              store_half_q;
	logic              is_bp_q;
	logic              last_q;

	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [TABLE_DEPTH-1:0] live_vec;
	logic                   match_found;
	logic [IDX_W-1:0]       match_idx;
	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;
	logic                   live_above;
	logic [IDX_W-1:0]       rd_idx;
	logic [ADDR_W-1:0]      rd_addr;
	logic                   rd_half;
	logic [WORD_W-1:0]      rd_saved;
	logic                   rd_active;
	logic [WORD_W-1:0]      restore_word;
	logic                   word_half;
	logic                   word_bad;

	logic              res_load;
	logic [STAT_W-1:0] res_status;
	logic              res_sv;
	logic [ADDR_W-1:0] res_addr;
	logic [WORD_W-1:0] res_data;
	logic              res_half;
	logic              res_bp;
	logic              res_last;
	logic              wr_new;
	logic              clr_active;
	logic              set_active;
	logic              clr_valid;
	logic              clr_all;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			address_q <= address;
			word_q    <= fetched_word;
		end
	end

	// Parallel compare of every entry against the held address, then lowest
	// match and lowest free slot.
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (entry_addr_q[i] == address_q);
		end
		live_vec = valid_q & active_q;
	end

	always_comb begin
		match_found = 1'b0;
		match_idx   = '0;
		free_found  = 1'b0;
		free_idx    = '0;
		live_above  = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (hit_vec[i] && !match_found) begin
				match_found = 1'b1;
				match_idx   = IDX_W'(i);
			end
			if (!valid_q[i] && !free_found) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
			if (live_vec[i] && (IDX_W'(i) > sweep_idx_q)) begin
				live_above = 1'b1;
			end
		end
	end

	// Single read port into the entry storage.
	assign rd_idx       = cmd.sweep_sel ? sweep_idx_q : match_idx;
	assign rd_addr      = entry_addr_q[rd_idx];
	assign rd_half      = entry_half_q[rd_idx];
	assign rd_saved     = entry_saved_q[rd_idx];
	assign rd_active    = active_q[rd_idx];
	assign restore_word = rd_half ? {16'h0000, rd_saved[15:0] & HALF_MASK} : rd_saved;

	// Instruction length from the low bits of the fetched word.
	assign word_half = (word_q[1:0] & LEN16_MASK) != LEN16_MASK;
	assign word_bad  = (word_q[4:0] & LEN32_MASK) == LEN32_MASK;

	always_comb begin
		res_status = ST_OK;
		res_sv     = 1'b0;
		res_addr   = '0;
		res_data   = '0;
		res_half   = 1'b0;
		res_bp     = 1'b0;
		res_last   = 1'b1;
		wr_new     = 1'b0;
		clr_active = 1'b0;
		set_active = 1'b0;
		clr_valid  = 1'b0;
		clr_all    = 1'b0;
		if (cmd.emit) begin
			res_sv   = 1'b1;
			res_addr = rd_addr;
			res_data = restore_word;
			res_half = rd_half;
			res_last = !live_above;
		end else begin
			case (action_q)
				ACT_SET: begin
					if (match_found) begin
						res_status = ST_EXISTS;
					end else if (word_bad) begin
						res_status = ST_INVALID;
					end else if (!free_found) begin
						res_status = ST_FULL;
					end else begin
						wr_new   = 1'b1;
						res_sv   = 1'b1;
						res_addr = address_q;
						res_data = word_half ? EBREAK16 : EBREAK32;
						res_half = word_half;
					end
				end
				ACT_CLEAR, ACT_DISABLE: begin
					if (!match_found) begin
						res_status = ST_NOT_FOUND;
					end else begin
						if (rd_active) begin
							res_sv     = 1'b1;
							res_addr   = address_q;
							res_data   = restore_word;
							res_half   = rd_half;
							clr_active = 1'b1;
						end
						clr_valid = (action_q == ACT_CLEAR);
					end
				end
				ACT_ENABLE: begin
					if (!match_found) begin
						res_status = ST_NOT_FOUND;
					end else if (!rd_active) begin
						res_sv     = 1'b1;
						res_addr   = address_q;
						res_data   = rd_half ? EBREAK16 : EBREAK32;
						res_half   = rd_half;
						set_active = 1'b1;
					end
				end
				ACT_QUERY: begin
					res_bp = match_found && rd_active;
				end
				ACT_CLEAR_ALL: begin
					// Only reached with no active entry: free everything.
					clr_all = 1'b1;
				end
				default: begin
					res_status = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			active_q    <= '0;
			sweep_idx_q <= '0;
		end else begin
			if (cmd.exec) begin
				if (wr_new) begin
					valid_q[free_idx]  <= 1'b1;
					active_q[free_idx] <= 1'b1;
				end
				if (clr_active) begin
					active_q[match_idx] <= 1'b0;
				end
				if (set_active) begin
					active_q[match_idx] <= 1'b1;
				end
				if (clr_valid) begin
					valid_q[match_idx] <= 1'b0;
				end
				if (clr_all) begin
					valid_q  <= '0;
					active_q <= '0;
				end
			end
			if (cmd.finish) begin
				valid_q     <= '0;
				active_q    <= '0;
				sweep_idx_q <= '0;
			end else begin
				if (cmd.emit) begin
					valid_q[sweep_idx_q]  <= 1'b0;
					active_q[sweep_idx_q] <= 1'b0;
				end
				if (cmd.advance) begin
					sweep_idx_q <= sweep_idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_new) begin
			entry_addr_q[free_idx]  <= address_q;
			entry_half_q[free_idx]  <= word_half;
			entry_saved_q[free_idx] <= word_q;
		end
	end

	assign res_load = cmd.exec || cmd.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q        <= res_status;
			store_valid_q   <= res_sv;
			store_address_q <= res_addr;
			store_data_q    <= res_data;
			store_half_q    <= res_half;
			is_bp_q         <= res_bp;
			last_q          <= res_last;
		end
	end

	assign stat.out_free     = !out_valid_q || out_ready;
	assign stat.is_clear_all = (action_q == ACT_CLEAR_ALL);
	assign stat.any_active   = |live_vec;
	assign stat.cur_hit      = live_vec[sweep_idx_q];
	assign stat.at_end       = (sweep_idx_q == LAST_IDX);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign store_valid   = store_valid_q;
	assign store_address = store_address_q;
	assign store_data    = store_data_q;
	assign store_half    = store_half_q;
	assign is_breakpoint = is_bp_q;
	assign last          = last_q;

endmodule

/* hdl/software_breakpoint_patch_table.sv */
// Software breakpoint patch table, top level.
// Instantiates sbpt_ctrl and sbpt_datapath; types come from sbpt_pkg.
//
// A debugger sends one request at a time on the input channel (in_valid /
// in_ready): an action code, the breakpoint address and, for a set, the
// instruction word fetched at that address. Each request produces one or
// more results on the output channel (out_valid / out_ready). A result
// carries a status code, an optional patch store (address, data, 16-bit
// flag) that also stands for a decode-cache invalidate at that address, the
// query answer, and a last flag on the final result of the request.
//
// Timing: a request is taken in the idle state and resolved in the exec state, where all
// entries are compared against the address in parallel; once the output register has
// room, out_valid rises and in_ready returns together at the end of the exec state.
// Clear-all with active entries instead walks the table one entry per cycle while no
// restore store waits on a stalled output, emitting one restore store per active entry
// in ascending entry order; with none active it gives a single plain result.
//
// The output register lets the block take the next request while a result
// still waits; a stalled receiver holds back the next result load and with it
// the return of in_ready. Reset empties the table and leaves both channels idle.
module software_breakpoint_patch_table import sbpt_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [ADDR_W-1:0] address,
	input  logic [WORD_W-1:0] fetched_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic              store_valid,
	output logic [ADDR_W-1:0] store_address,
	output logic [WORD_W-1:0] store_data,
	output logic              store_half,
	output logic              is_breakpoint,
	output logic              last
);

	sbpt_cmd_t  cmd;
	sbpt_stat_t stat;

	// The controller sequences each request; the datapath owns the table.
	sbpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sbpt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (action),
		.address       (address),
		.fetched_word  (fetched_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.store_valid   (store_valid),
		.store_address (store_address),
		.store_data    (store_data),
		.store_half    (store_half),
		.is_breakpoint (is_breakpoint),
		.last          (last)
	);

endmodule

/* hdl/sbpt_checker.sv */
// Port-level checks for the breakpoint patch table, bound to the top level.
// Depends on sbpt_pkg for status codes and field widths.
module sbpt_checker import sbpt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [STAT_W-1:0] status,
	input logic              store_valid,
	input logic [ADDR_W-1:0] store_address,
	input logic [WORD_W-1:0] store_data,
	input logic              store_half,
	input logic              is_breakpoint,
	input logic              last
);

	// A held result keeps its payload until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(store_data) &&
		$stable(store_address) && $stable(status) && $stable(last))
		else $error("output result changed while stalled");

	// Requests are handled one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in progress");

	// A result without a store carries zero store fields.
	a_no_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !store_valid |->
		store_address == '0 && store_data == '0 && !store_half)
		else $error("store fields set without a store");

	// A 16-bit store never carries data in the upper half.
	a_half_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_half |-> store_valid && store_data[31:16] == 16'h0000)
		else $error("16-bit store with upper data bits set");

	// Error results and query answers are single plain results.
	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK || is_breakpoint) |-> !store_valid && last)
		else $error("error or query result carries a store or is not last");

endmodule

bind software_breakpoint_patch_table sbpt_checker u_sbpt_checker (.*);

/* tb/tb_software_breakpoint_patch_table.sv */
// Self-checking testbench for software_breakpoint_patch_table.
// Depends on sbpt_pkg for port widths, action and status codes and encodings;
// predicts each result in SystemVerilog or takes it from a typed row, and compares each field by field.
`timescale 1ns / 100ps

module tb_software_breakpoint_patch_table;
	import sbpt_pkg::*;

	localparam int TABLE_DEPTH  = 16;
	localparam int DIRECTED_LEN = 25;
	localparam int RANDOM_ITEMS = 335;
	// Cycles with no handshake on either channel before the run is declared hung.
	// The longest legal quiet stretch is a sender gap, a receiver stall or the
	// end-of-run tail; this is many times all of them.
	localparam int QUIET_LIMIT  = 4000;
	localparam int REPORT_LIMIT = 40;

	// Action codes the block does not define; they must answer plain OK.
	localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

	localparam logic [ADDR_W-1:0] ADDR_LOW  = 64'h0000_0000_0000_0000;
	localparam logic [ADDR_W-1:0] ADDR_HIGH = 64'hffff_ffff_ffff_ffff;
	localparam logic [ADDR_W-1:0] ADDR_A    = 64'h8000_0000_0000_0002;
	localparam logic [ADDR_W-1:0] ADDR_B    = 64'h0000_0000_8000_1000;
	localparam logic [ADDR_W-1:0] ADDR_C    = 64'h5555_aaaa_5555_aaaa;

	// One result as it leaves the block.
	typedef struct {
		logic [STAT_W-1:0] status;
		logic              store_valid;
		logic [ADDR_W-1:0] store_address;
		logic [WORD_W-1:0] store_data;
		logic              store_half;
		logic              is_breakpoint;
		logic              last;
	} bp_result_t;

	// One directed request. When typed is set, the single result is given in
	// the row (the store address is the row address whenever a store is made);
	// otherwise the result comes from the predictor.
	typedef struct {
		logic [ACT_W-1:0]  act;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] word;
		bit                typed;
		logic [STAT_W-1:0] status;
		logic              store_valid;
		logic [WORD_W-1:0] store_data;
		logic              store_half;
		logic              is_breakpoint;
	} request_row_t;

	// The directed part walks the corners: every command against an empty
	// table, an invalid instruction length, the highest and lowest addresses,
	// a duplicate set, disable and enable of entries already in that state,
	// clear of inactive and active entries, the two spare action codes, a
	// 16-bit restore whose upper half is nonzero, and a clear-all that has to
	// skip a disabled entry while restoring the others in table order.
	request_row_t directed_rows [DIRECTED_LEN] = '{
		'{ACT_QUERY,     ADDR_LOW,  32'h0000_0000, 1'b1, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_CLEAR,     ADDR_LOW,  32'h0000_0000, 1'b1, ST_NOT_FOUND, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_DISABLE,   ADDR_LOW,  32'h0000_0000, 1'b1, ST_NOT_FOUND, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_ENABLE,    ADDR_LOW,  32'h0000_0000, 1'b1, ST_NOT_FOUND, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_CLEAR_ALL, ADDR_HIGH, 32'hffff_ffff, 1'b1, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_SET,       ADDR_LOW,  32'hffff_ffff, 1'b1, ST_INVALID,   1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_SET,       ADDR_HIGH, 32'h0000_0000, 1'b1, ST_OK,        1'b1, EBREAK16, 1'b1, 1'b0},
		'{ACT_SET,       ADDR_LOW,  32'hffff_fff3, 1'b1, ST_OK,        1'b1, EBREAK32, 1'b0, 1'b0},
		'{ACT_SET,       ADDR_LOW,  32'h0000_0000, 1'b1, ST_EXISTS,    1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_QUERY,     ADDR_LOW,  32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_DISABLE,   ADDR_LOW,  32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_DISABLE,   ADDR_LOW,  32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_QUERY,     ADDR_LOW,  32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_ENABLE,    ADDR_LOW,  32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_ENABLE,    ADDR_LOW,  32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_DISABLE,   ADDR_HIGH, 32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_CLEAR,     ADDR_HIGH, 32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_CLEAR,     ADDR_LOW,  32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_SPARE6,    ADDR_HIGH, 32'hffff_ffff, 1'b1, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_SPARE7,    ADDR_LOW,  32'h0000_0000, 1'b1, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_SET,       ADDR_A,    32'hffff_fffe, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_SET,       ADDR_B,    32'h8000_001b, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_SET,       ADDR_C,    32'h1234_5601, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_DISABLE,   ADDR_B,    32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0},
		'{ACT_CLEAR_ALL, ADDR_LOW,  32'h0000_0000, 1'b0, ST_OK,        1'b0, 32'h0, 1'b0, 1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [ACT_W-1:0]  action = ACT_SET;
	logic [ADDR_W-1:0] address = '0;
	logic [WORD_W-1:0] fetched_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic              store_valid;
	logic [ADDR_W-1:0] store_address;
	logic [WORD_W-1:0] store_data;
	logic              store_half;
	logic              is_breakpoint;
	logic              last;

	// Predicted breakpoint table: the same entries the block keeps.
	bit                bp_used  [TABLE_DEPTH];
	bit                bp_armed [TABLE_DEPTH];
	logic [ADDR_W-1:0] bp_addr  [TABLE_DEPTH];
	bit                bp_half  [TABLE_DEPTH];
	logic [WORD_W-1:0] bp_orig  [TABLE_DEPTH];

	// Results predicted for accepted requests and not yet seen at the output.
	bp_result_t awaited_results [$];

	int mismatches   = 0;
	int quiet_cycles = 0;
	int requests_sent = 0;
	int burst_left   = 0;
	bit steady       = 1'b0;

	logic [ADDR_W-1:0] addr_pool [8];
	logic [15:0] ready_pattern = 16'hffff;
	int          pattern_age   = 0;

	software_breakpoint_patch_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.address      (address),
		.fetched_word (fetched_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.store_valid  (store_valid),
		.store_address(store_address),
		.store_data   (store_data),
		.store_half   (store_half),
		.is_breakpoint(is_breakpoint),
		.last         (last)
	);

	always #2 clk = ~clk;

	// Append one predicted result behind those already waiting.
	function automatic void await_result(input bp_result_t res);
		awaited_results.insert(awaited_results.size(), res);
	endfunction

	// Work out the results of one accepted request and update the predicted
	// table. With record cleared the table still moves but nothing is queued,
	// because the caller supplies the result itself.
	function automatic void apply_debug_command(input logic [ACT_W-1:0] act,
			input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] word, input bit record);
		int         hit;
		int         slot;
		int         armed_count;
		int         emitted;
		bit         half;
		bp_result_t r;
		bp_result_t sweep_r;

		hit = -1;
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (hit < 0 && bp_used[i] && bp_addr[i] == addr)
				hit = i;
		r = '{ST_OK, 1'b0, '0, '0, 1'b0, 1'b0, 1'b1};

		case (act)
			ACT_SET: begin
				half = (word[1:0] != LEN16_MASK);
				slot = -1;
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (slot < 0 && !bp_used[i])
						slot = i;
				// Duplicate beats a bad length, which beats a full table.
				if (hit >= 0)
					r.status = ST_EXISTS;
				else if (!half && word[4:0] == LEN32_MASK)
					r.status = ST_INVALID;
				else if (slot < 0)
					r.status = ST_FULL;
				else begin
					bp_used[slot]  = 1'b1;
					bp_armed[slot] = 1'b1;
					bp_addr[slot]  = addr;
					bp_half[slot]  = half;
					bp_orig[slot]  = word;
					r.store_valid   = 1'b1;
					r.store_address = addr;
					r.store_data    = half ? EBREAK16 : EBREAK32;
					r.store_half    = half;
				end
			end
			ACT_CLEAR, ACT_DISABLE: begin
				if (hit < 0)
					r.status = ST_NOT_FOUND;
				else begin
					if (bp_armed[hit]) begin
						r.store_valid   = 1'b1;
						r.store_address = addr;
						r.store_data    = bp_half[hit] ? {16'h0, bp_orig[hit][15:0] & HALF_MASK}
						                               : bp_orig[hit];
						r.store_half    = bp_half[hit];
						bp_armed[hit]   = 1'b0;
					end
					if (act == ACT_CLEAR)
						bp_used[hit] = 1'b0;
				end
			end
			ACT_ENABLE: begin
				if (hit < 0)
					r.status = ST_NOT_FOUND;
				else if (!bp_armed[hit]) begin
					r.store_valid   = 1'b1;
					r.store_address = addr;
					r.store_data    = bp_half[hit] ? EBREAK16 : EBREAK32;
					r.store_half    = bp_half[hit];
					bp_armed[hit]   = 1'b1;
				end
			end
			ACT_QUERY: begin
				r.is_breakpoint = (hit >= 0) && bp_armed[hit];
			end
			ACT_CLEAR_ALL: begin
				// One restore per armed entry in slot order; last marks the final
				// one. An empty sweep still answers with a single plain result.
				armed_count = 0;
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (bp_used[i] && bp_armed[i])
						armed_count++;
				emitted = 0;
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (bp_used[i] && bp_armed[i]) begin
						emitted++;
						sweep_r = '{ST_OK, 1'b1, bp_addr[i],
							bp_half[i] ? {16'h0, bp_orig[i][15:0] & HALF_MASK} : bp_orig[i],
							bp_half[i], 1'b0, emitted == armed_count};
						if (record)
							await_result(sweep_r);
					end
					bp_used[i]  = 1'b0;
					bp_armed[i] = 1'b0;
				end
				if (emitted != 0)
					record = 1'b0;
			end
			default: begin
			end
		endcase

		if (record)
			await_result(r);
	endfunction

	// Offer one request and hold it until the block takes it. The sender runs
	// in bursts; a gap of random length may open before a new burst starts,
	// unless the current sequence runs steady.
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr,
			input logic [WORD_W-1:0] word, input bit typed);
		int gap;

		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid     <= 1'b1;
		action       <= act;
		address      <= addr;
		fetched_word <= word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
		apply_debug_command(act, addr, word, !typed);
	endtask

	// Stop sending and wait until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Weighted toward commands that find entries; clear-all and the spare codes
	// stay rare so the table has time to fill.
	function automatic logic [ACT_W-1:0] pick_action();
		int r;

		r = $urandom_range(0, 99);
		if (r < 28)
			return ACT_SET;
		else if (r < 40)
			return ACT_CLEAR;
		else if (r < 55)
			return ACT_DISABLE;
		else if (r < 70)
			return ACT_ENABLE;
		else if (r < 90)
			return ACT_QUERY;
		else if (r < 95)
			return ACT_CLEAR_ALL;
		else if (r < 98)
			return ACT_SPARE6;
		else
			return ACT_SPARE7;
	endfunction

	// Mostly pool addresses, so that commands hit existing entries.
	function automatic logic [ADDR_W-1:0] pick_address();
		if ($urandom_range(0, 9) < 8)
			return addr_pool[$urandom_range(0, 7)];
		return {$urandom, $urandom};
	endfunction

	// Random word with a controlled mix of 16-bit, 32-bit and invalid lengths.
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;

		w = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2: w[1:0] = 2'($urandom_range(0, 2));
			3, 4, 5: begin
				w[1:0] = LEN16_MASK;
				w[4:2] = 3'($urandom_range(0, 6));
			end
			6: w[4:0] = LEN32_MASK;
			default: begin
			end
		endcase
		return w;
	endfunction

	function automatic void refresh_pool();
		for (int i = 0; i < 8; i++)
			addr_pool[i] = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: addr_pool[$urandom_range(0, 7)] = ADDR_LOW;
			1: addr_pool[$urandom_range(0, 7)] = ADDR_HIGH;
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0d ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// Result checker: every accepted result is matched against the oldest one
	// predicted. Inputs and outputs are read at the edge before any update of
	// that edge lands, so both sides see the same handshake.
	always @(posedge clk) begin : result_check
		bp_result_t want;

		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0d ns: result expected none, got status %0h store %0b at %0h",
						$time, status, store_valid, store_address);
			end else begin
				want = awaited_results.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("store_valid", 64'(want.store_valid), 64'(store_valid));
				check_field("store_address", want.store_address, store_address);
				check_field("store_data", 64'(want.store_data), 64'(store_data));
				check_field("store_half", 64'(want.store_half), 64'(store_half));
				check_field("is_breakpoint", 64'(want.is_breakpoint), 64'(is_breakpoint));
				check_field("last", 64'(want.last), 64'(last));
			end
		end
	end

	// Receiver: out_ready follows a rotating sixteen-bit pattern that is reloaded
	// whenever pattern_age wraps, sometimes with all ones so that stretches with
	// no stall occur, otherwise with random bits giving stalls of any phase.
	always @(posedge clk) begin
		if (pattern_age == 63) begin
			pattern_age <= 0;
			if ($urandom_range(0, 3) == 0)
				ready_pattern <= 16'hffff;
			else
				ready_pattern <= 16'($urandom) | (16'h1 << $urandom_range(0, 15));
		end else begin
			pattern_age   <= pattern_age + 1;
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
		end
		out_ready <= ready_pattern[0];
	end

	// Watchdog: a long run of cycles with no handshake on either side means
	// the block has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("software_breakpoint_patch_table: mismatch");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		request_row_t row;
		bp_result_t   typed_res;
		int           extra;
		int           seq_len;
		logic [ADDR_W-1:0] a;
		logic [WORD_W-1:0] w;

		for (int i = 0; i < TABLE_DEPTH; i++) begin
			bp_used[i]  = 1'b0;
			bp_armed[i] = 1'b0;
		end
		refresh_pool();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Typed rows carry their own answer; the predictor still
		// tracks the table through them.
		for (int i = 0; i < DIRECTED_LEN; i++) begin
			row = directed_rows[i];
			send_request(row.act, row.addr, row.word, row.typed);
			if (row.typed) begin
				typed_res = '{row.status, row.store_valid,
					row.store_valid ? row.addr : ADDR_LOW, row.store_data, row.store_half,
					row.is_breakpoint, 1'b1};
				await_result(typed_res);
			end
		end
		drain_results();

		// Random part, built from sequences: table fills that end in full and
		// duplicate sets, runs of commands on a small address pool, and noise.
		while (requests_sent < DIRECTED_LEN + RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					send_request(ACT_CLEAR_ALL, pick_address(), pick_word(), 1'b0);
					for (int k = 0; k < TABLE_DEPTH; k++) begin
						a = {$urandom, $urandom};
						w = pick_word();
						if (w[4:0] == LEN32_MASK)
							w[0] = 1'b0;
						addr_pool[k % 8] = a;
						send_request(ACT_SET, a, w, 1'b0);
					end
					extra = $urandom_range(1, 3);
					repeat (extra)
						send_request(ACT_SET, {$urandom, $urandom}, pick_word(), 1'b0);
					send_request(ACT_SET, addr_pool[$urandom_range(0, 7)], pick_word(), 1'b0);
					seq_len = $urandom_range(4, 10);
					repeat (seq_len)
						send_request(pick_action(), pick_address(), pick_word(), 1'b0);
				end
				3, 4, 5: begin
					seq_len = $urandom_range(3, 8);
					repeat (seq_len)
						send_request(3'($urandom_range(0, 7)), {$urandom, $urandom}, $urandom,
							1'b0);
				end
				default: begin
					if ($urandom_range(0, 4) == 0)
						refresh_pool();
					seq_len = $urandom_range(8, 15);
					repeat (seq_len)
						send_request(pick_action(), pick_address(), pick_word(), 1'b0);
				end
			endcase
			if ($urandom_range(0, 9) == 0)
				drain_results();
		end

		// Wait for the last results, then a tail long enough for a full sweep
		// so that any stray extra result is caught.
		drain_results();
		repeat (TABLE_DEPTH + 16) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("software_breakpoint_patch_table: match");
		else
			$display("software_breakpoint_patch_table: mismatch");
		$finish;
	end

endmodule
